@@ src/rational_arith_reduce_defines.svh @@
// Assertion macros for the rational arithmetic block.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RAR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rar_pkg.sv @@
// Shared types and constants for the rational arithmetic block.
package rar_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int ACTION_W      = 3;
	localparam int ORDER_W       = 2;
	localparam int S_TDATA_W     = 4 * FIELD_W;
	localparam int M_TDATA_W     = 72;

	localparam logic [ORDER_W-1:0] ORD_LESS    = 2'b11;
	localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'b00;
	localparam logic [ORDER_W-1:0] ORD_GREATER = 2'b01;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD    = 3'd0,
		ACT_SUB    = 3'd1,
		ACT_MUL    = 3'd2,
		ACT_DIV    = 3'd3,
		ACT_CMP    = 3'd4,
		ACT_REDUCE = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMB,
		ST_GCD,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

@@ src/rational_arith_reduce.sv @@
// Rational add, subtract, multiply, divide, compare and reduce on a shared sequencer.
//
//   port group   dir  payload
//   s_t*         in   tuser: action; tdata: a_num, a_den, b_num, b_den
//   m_t*         out  tdata: res_num, res_den, order, zero pad
//
// Products: one signed multiplier, two products (three for add and subtract). GCD:
// binary subtract-and-shift loop. Division by the GCD: one restoring divider,
// numerator first, then denominator. Reset clears the sequencer and the output
// valid; no clearing pass.
// A new request is taken while the last result still waits on m_tready.
`include "rational_arith_reduce_defines.svh"

module rational_arith_reduce #(
	parameter int WORD_BITS = rar_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rar_pkg::S_TDATA_W-1:0]    s_tdata,  // a_num, a_den, b_num, b_den
	input  logic [rar_pkg::ACTION_W-1:0]     s_tuser,  // action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rar_pkg::M_TDATA_W-1:0]    m_tdata   // res_num, res_den, order, zero pad
);

	localparam int W     = WORD_BITS;
	localparam int FW    = rar_pkg::FIELD_W;
	localparam int OW    = rar_pkg::ORDER_W;
	localparam int CNT_W = $clog2(W);
	localparam int PAD_W = rar_pkg::M_TDATA_W - 2 * FW - OW;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		mag = x[W-1] ? ({W{1'b0}} - x) : x;
	endfunction

	rar_pkg::state_t state_q, state_d;

	logic [rar_pkg::ACTION_W-1:0] act_q;
	logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic [1:0]            idx_q;
	logic signed [2*W-1:0] p0_q, p1_q, p2_q;
	logic signed [W-1:0]   num_q, den_q;
	logic [W-1:0]          u_q, v_q, g_q, dq_q, r_q, qn_q;
	logic [CNT_W-1:0]      k_q, cnt_q;
	logic                  sel_q;
	logic signed [W-1:0]   rn_q, rd_q;
	logic [OW-1:0]         ro_q;
	logic                  m_tvalid_q;
	logic signed [FW-1:0]  out_num_q, out_den_q;
	logic [OW-1:0]         out_ord_q;

	logic                  accept, out_free, out_load;
	logic [1:0]            last_mul;
	logic signed [W-1:0]   opa, opb;
	logic signed [2*W-1:0] prod;
	logic signed [W-1:0]   comb_num, comb_den;
	logic signed [W-1:0]   dir_num, dir_den;
	logic [OW-1:0]         dir_ord, cmp_ord;
	logic                  is_mul, skip_div, go_gcd;
	logic                  u_even, v_even;
	logic [W-1:0]          u_sub, v_sub;
	logic [W:0]            rs, dsub;
	logic                  dfit;
	logic [W-1:0]          dq_next;
	logic [W-1:0]          fn, fd;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == rar_pkg::ST_DONE) && out_free;
	assign s_tready = (state_q == rar_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_ord_q, out_den_q, out_num_q};

	// Shared multiplier operands.
	assign is_mul   = (act_q == rar_pkg::ACT_MUL);
	assign last_mul = (act_q == rar_pkg::ACT_ADD || act_q == rar_pkg::ACT_SUB) ? 2'd2 : 2'd1;

	always_comb begin
		case (idx_q)
			2'd0: begin
				opa = an_q;
				opb = is_mul ? bn_q : bd_q;
			end
			2'd1: begin
				opa = is_mul ? ad_q : bn_q;
				opb = is_mul ? bd_q : ad_q;
			end
			default: begin
				opa = ad_q;
				opb = bd_q;
			end
		endcase
	end

	assign prod = opa * opb;

	// Combine products into the unreduced fraction.
	always_comb begin
		case (act_q)
			rar_pkg::ACT_ADD: begin
				comb_num = p0_q[W-1:0] + p1_q[W-1:0];
				comb_den = p2_q[W-1:0];
			end
			rar_pkg::ACT_SUB: begin
				comb_num = p0_q[W-1:0] - p1_q[W-1:0];
				comb_den = p2_q[W-1:0];
			end
			rar_pkg::ACT_MUL, rar_pkg::ACT_DIV: begin
				comb_num = p0_q[W-1:0];
				comb_den = p1_q[W-1:0];
			end
			default: begin
				comb_num = an_q;
				comb_den = ad_q;
			end
		endcase
	end

	assign cmp_ord  = (p0_q < p1_q) ? rar_pkg::ORD_LESS :
			  (p0_q > p1_q) ? rar_pkg::ORD_GREATER : rar_pkg::ORD_EQUAL;
	assign skip_div = (act_q == rar_pkg::ACT_DIV) && (bn_q == '0);

	always_comb begin
		dir_num = '0;
		dir_den = '0;
		dir_ord = rar_pkg::ORD_EQUAL;
		go_gcd  = 1'b0;
		case (act_q)
			rar_pkg::ACT_CMP: begin
				dir_ord = cmp_ord;
			end
			rar_pkg::ACT_ADD, rar_pkg::ACT_SUB, rar_pkg::ACT_MUL,
			rar_pkg::ACT_DIV, rar_pkg::ACT_REDUCE: begin
				if (skip_div) begin
					dir_num = an_q;
					dir_den = ad_q;
				end else begin
					dir_num = comb_num;
					dir_den = comb_den;
					go_gcd  = (comb_num != '0) && (comb_den != '0);
				end
			end
			default: begin
				dir_num = '0;
			end
		endcase
	end

	// Binary GCD step.
	assign u_even = !u_q[0];
	assign v_even = !v_q[0];
	assign u_sub  = u_q - v_q;
	assign v_sub  = v_q - u_q;

	// Restoring divider step.
	assign rs      = {r_q, dq_q[W-1]};
	assign dsub    = rs - {1'b0, g_q};
	assign dfit    = !dsub[W];
	assign dq_next = {dq_q[W-2:0], dfit};

	// Restore signs, then make the denominator positive.
	assign fn = num_q[W-1] ? ({W{1'b0}} - qn_q) : qn_q;
	assign fd = den_q[W-1] ? ({W{1'b0}} - dq_q) : dq_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser inside {[rar_pkg::ACT_ADD:rar_pkg::ACT_CMP]})
						state_d = rar_pkg::ST_MUL;
					else
						state_d = rar_pkg::ST_COMB;
				end
			end
			rar_pkg::ST_MUL: begin
				if (idx_q == last_mul)
					state_d = rar_pkg::ST_COMB;
			end
			rar_pkg::ST_COMB: begin
				state_d = go_gcd ? rar_pkg::ST_GCD : rar_pkg::ST_DONE;
			end
			rar_pkg::ST_GCD: begin
				if (u_q == '0)
					state_d = rar_pkg::ST_DIV;
			end
			rar_pkg::ST_DIV: begin
				if (cnt_q == CNT_LAST && sel_q)
					state_d = rar_pkg::ST_FIX;
			end
			rar_pkg::ST_FIX: begin
				state_d = rar_pkg::ST_DONE;
			end
			rar_pkg::ST_DONE: begin
				if (out_free)
					state_d = rar_pkg::ST_IDLE;
			end
			default: begin
				state_d = rar_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rar_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			sel_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				rar_pkg::ST_IDLE: idx_q <= '0;
				rar_pkg::ST_MUL:  idx_q <= idx_q + 2'd1;
				rar_pkg::ST_COMB: k_q <= '0;
				rar_pkg::ST_GCD: begin
					if (u_q == '0) begin
						cnt_q <= '0;
						sel_q <= 1'b0;
					end else if (u_even && v_even) begin
						k_q <= k_q + 1'b1;
					end
				end
				rar_pkg::ST_DIV: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q <= '0;
						sel_q <= !sel_q;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (accept) begin
					act_q <= s_tuser;
					an_q  <= s_tdata[0*FW +: W];
					ad_q  <= s_tdata[1*FW +: W];
					bn_q  <= s_tdata[2*FW +: W];
					bd_q  <= s_tdata[3*FW +: W];
				end
			end
			rar_pkg::ST_MUL: begin
				case (idx_q)
					2'd0:    p0_q <= prod;
					2'd1:    p1_q <= prod;
					default: p2_q <= prod;
				endcase
			end
			rar_pkg::ST_COMB: begin
				rn_q  <= dir_num;
				rd_q  <= dir_den;
				ro_q  <= dir_ord;
				num_q <= comb_num;
				den_q <= comb_den;
				u_q   <= mag(comb_num);
				v_q   <= mag(comb_den);
			end
			rar_pkg::ST_GCD: begin
				if (u_q == '0) begin
					g_q  <= v_q << k_q;
					dq_q <= mag(num_q);
					r_q  <= '0;
				end else if (u_even && v_even) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
				end else if (u_even) begin
					u_q <= u_q >> 1;
				end else if (v_even) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_sub >> 1;
				end else begin
					v_q <= v_sub >> 1;
				end
			end
			rar_pkg::ST_DIV: begin
				if (cnt_q == CNT_LAST && !sel_q) begin
					qn_q <= dq_next;
					dq_q <= mag(den_q);
					r_q  <= '0;
				end else begin
					dq_q <= dq_next;
					r_q  <= dfit ? dsub[W-1:0] : rs[W-1:0];
				end
			end
			rar_pkg::ST_FIX: begin
				ro_q <= rar_pkg::ORD_EQUAL;
				if (fd[W-1]) begin
					rn_q <= {W{1'b0}} - fn;
					rd_q <= {W{1'b0}} - fd;
				end else begin
					rn_q <= fn;
					rd_q <= fd;
				end
			end
			rar_pkg::ST_DONE: begin
				if (out_load) begin
					out_num_q <= FW'(rn_q);
					out_den_q <= FW'(rd_q);
					out_ord_q <= ro_q;
				end
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	`RAR_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after request")
	`RAR_ASSERT_IMPL(a_gcd_v_nonzero, state_q == rar_pkg::ST_GCD, v_q != '0, "GCD operand zero")
	`RAR_ASSERT_IMPL(a_div_rem_below, state_q == rar_pkg::ST_DIV, (g_q != '0) && (r_q < g_q), "remainder not below divisor")

endmodule

@@ tb/sv/rar_fraction_check.sv @@
// Checker for rational_arith_reduce: predicts each request's result fraction and compares.
module rar_fraction_check
	import rar_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // a_num, a_den, b_num, b_den
	input  logic [ACTION_W-1:0]  s_tuser,   // action
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // res_num, res_den, order, zero pad
	output int                   fault_count,
	output int                   outstanding
);

	typedef logic [FIELD_W-1:0] word_t;

	typedef struct packed {
		word_t               num;
		word_t               den;
		logic [ORDER_W-1:0]  order;
	} fraction_t;

	fraction_t expected_fracs[$];

	function automatic word_t magnitude_of(word_t v);
		return v[FIELD_W-1] ? -v : v;
	endfunction

	function automatic fraction_t reduce_fraction(word_t num, word_t den);
		word_t x;
		word_t y;
		word_t t;
		fraction_t r;
		r = '{num: num, den: den, order: ORD_EQUAL};
		if (num == '0 || den == '0)
			return r;
		x = magnitude_of(num);
		y = magnitude_of(den);
		while (y != '0) begin
			t = y;
			y = x % y;
			x = t;
		end
		if (x > 1) begin
			r.num = num[FIELD_W-1] ? -(magnitude_of(num) / x) : magnitude_of(num) / x;
			r.den = den[FIELD_W-1] ? -(magnitude_of(den) / x) : magnitude_of(den) / x;
		end
		if (r.den[FIELD_W-1]) begin
			r.num = -r.num;
			r.den = -r.den;
		end
		return r;
	endfunction

	function automatic fraction_t predict_fraction(logic [ACTION_W-1:0] act, word_t an,
			word_t ad, word_t bn, word_t bd);
		fraction_t r;
		longint lhs_prod;
		longint rhs_prod;
		r = '0;
		case (act)
		ACT_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
		ACT_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
		ACT_MUL: r = reduce_fraction(an * bn, ad * bd);
		ACT_DIV: begin
			if (bn == '0) begin
				r.num = an;
				r.den = ad;
			end else begin
				r = reduce_fraction(an * bd, ad * bn);
			end
		end
		ACT_CMP: begin
			lhs_prod = longint'(signed'(an)) * longint'(signed'(bd));
			rhs_prod = longint'(signed'(bn)) * longint'(signed'(ad));
			if (lhs_prod < rhs_prod)
				r.order = ORD_LESS;
			else if (lhs_prod > rhs_prod)
				r.order = ORD_GREATER;
			else
				r.order = ORD_EQUAL;
		end
		ACT_REDUCE: r = reduce_fraction(an, ad);
		default: r = '0;
		endcase
		return r;
	endfunction

	task automatic note_fault(string what, fraction_t want, fraction_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t %s: expected num %0d den %0d order %0d, got num %0d den %0d order %0d",
				$time, what, signed'(want.num), signed'(want.den), signed'(want.order),
				signed'(got.num), signed'(got.den), signed'(got.order));
	endtask

	initial begin
		fault_count = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		fraction_t got;
		fraction_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.num   = m_tdata[FIELD_W-1:0];
				got.den   = m_tdata[2*FIELD_W-1:FIELD_W];
				got.order = m_tdata[2*FIELD_W+ORDER_W-1:2*FIELD_W];
				if (expected_fracs.size() == 0) begin
					note_fault("result with no request pending", '0, got);
				end else begin
					want = expected_fracs.pop_front();
					if (got.num !== want.num || got.den !== want.den || got.order !== want.order)
						note_fault("result mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready)
				expected_fracs.push_back(predict_fraction(s_tuser, s_tdata[FIELD_W-1:0],
					s_tdata[2*FIELD_W-1:FIELD_W], s_tdata[3*FIELD_W-1:2*FIELD_W],
					s_tdata[4*FIELD_W-1:3*FIELD_W]));
			outstanding = expected_fracs.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the rational_arith_reduce testbench: clock, reset, requests, back-pressure, verdict.
module testbench;
	import rar_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam logic [FIELD_W-1:0]  WORD_MIN     = 32'h8000_0000;
	localparam logic [FIELD_W-1:0]  WORD_MAX     = 32'h7FFF_FFFF;
	localparam logic [FIELD_W-1:0]  WORD_ONES    = 32'hFFFF_FFFF;
	localparam int                  RANDOM_PER_PHASE = 307;
	localparam int                  DRAIN_CYCLES     = 4 * WORD_BITS_DEF + 16;

	localparam logic [ACTION_W-1:0] ACTION_CODES [8] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV,
		ACT_CMP, ACT_REDUCE, ACT_SPARE_LO, ACT_SPARE_HI};
	localparam int SEND_IDLE_PCT  [4] = '{0, 83, 0, 20};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 83, 20};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // a_num, a_den, b_num, b_den
	logic [ACTION_W-1:0]  s_tuser;   // action
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // res_num, res_den, order, zero pad
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   fault_count;
	int                   outstanding;

	rational_arith_reduce dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rar_fraction_check fraction_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fault_count (fault_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Enter and leave at a falling edge; hold the request until accepted.
	task automatic send_request(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] an,
			logic [FIELD_W-1:0] ad, logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {bd, bn, ad, an};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
		0: begin
			case ($urandom_range(0, 4))
			0: return '0;
			1: return 1;
			2: return WORD_ONES;
			3: return WORD_MIN;
			default: return WORD_MAX;
			endcase
		end
		1, 2, 3: return $urandom_range(0, 128) - 64;
		4, 5: return ($urandom_range(0, 2000) - 1000) * $urandom_range(1, 720);
		default: return $urandom();
		endcase
	endfunction

	task automatic random_request();
		logic [ACTION_W-1:0] act;
		logic [FIELD_W-1:0]  an;
		logic [FIELD_W-1:0]  ad;
		logic [FIELD_W-1:0]  bn;
		logic [FIELD_W-1:0]  bd;
		logic [FIELD_W-1:0]  scale;
		if ($urandom_range(0, 19) < 18)
			act = ACTION_CODES[$urandom_range(0, 5)];
		else
			act = ACTION_CODES[$urandom_range(6, 7)];
		an = rand_word();
		ad = rand_word();
		bn = rand_word();
		bd = rand_word();
		// Scale the first fraction now and then so compare finds equal pairs.
		if (act == ACT_CMP && $urandom_range(0, 3) == 0) begin
			scale = $urandom_range(1, 50);
			bn = an * scale;
			bd = ad * scale;
		end
		send_request(act, an, ad, bn, bd);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = ACT_ADD;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(ACT_ADD, 1, 2, 1, 3);
		send_request(ACT_SUB, 1, 2, 1, 2);
		send_request(ACT_MUL, -3, 4, 8, -6);
		send_request(ACT_DIV, 1, 2, 0, 5);
		send_request(ACT_DIV, 3, 4, -9, 8);
		send_request(ACT_DIV, WORD_MIN, WORD_ONES, WORD_ONES, 1);
		send_request(ACT_CMP, 1, 2, 1, 3);
		send_request(ACT_CMP, -1, 2, 1, 3);
		send_request(ACT_CMP, 2, 4, 1, 2);
		send_request(ACT_CMP, WORD_MIN, 1, WORD_MAX, 1);
		send_request(ACT_CMP, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX);
		send_request(ACT_CMP, 0, 0, 0, 0);
		send_request(ACT_REDUCE, 0, -7, 5, 5);
		send_request(ACT_REDUCE, 5, 0, 1, 1);
		send_request(ACT_REDUCE, 6, -4, 0, 0);
		send_request(ACT_REDUCE, WORD_MIN, WORD_MIN, 0, 0);
		send_request(ACT_REDUCE, 1, WORD_MIN, 0, 0);
		send_request(ACT_REDUCE, WORD_MIN, -2, 0, 0);
		send_request(ACT_REDUCE, WORD_MAX, WORD_MAX, 0, 0);
		send_request(ACT_ADD, WORD_MAX, 1, 1, 1);
		send_request(ACT_ADD, 0, 0, 0, 0);
		send_request(ACT_MUL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
		send_request(ACT_SUB, WORD_MIN, 1, WORD_MAX, 1);
		send_request(ACT_SPARE_LO, 3, 4, 5, 6);
		send_request(ACT_SPARE_HI, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			repeat (RANDOM_PER_PHASE) random_request();
		end
		s_tvalid = 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
